// ----- src/ffea_pkg.sv -----
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types and constants of the first-fit extent allocator: the table
// entry layout, operation and status codes, sequencer states and the
// request/response structs of the shared adder.
// ----------------------------------------------------------------------------
package ffea_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 16;
   localparam int DATA_W              = 32;
   localparam int HANDLE_W            = 16;

   localparam logic [DATA_W-1:0] CAPACITY_RESET = 32'hFFFF_FFFF;

   // operation codes carried on the input tuser bit
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_NOFIT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SPLIT_CHK,
      S_CARVE,
      S_SHIFT,
      S_FINISH
   } state_type;

   // one free extent
   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [DATA_W-1:0]   offset;
      logic [DATA_W-1:0]   size;
   } entry_type;

   // shared adder operation
   typedef struct packed {
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic              sub;
   } alu_op_type;

   typedef struct packed {
      logic [DATA_W-1:0] res;
      logic              carry;
   } alu_res_type;

   // one result item
   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] grant_handle;
      logic [DATA_W-1:0]   grant_offset;
      logic [DATA_W-1:0]   granted_size;
   } rsp_type;

endpackage

// ----- src/first_fit_extent_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_extent_allocator
// First-fit free-extent allocator with an ordered table of extents.
// ----------------------------------------------------------------------------
// An add transfer appends the extent in the accept cycle, and the result is
// then loaded into the output register. An allocate transfer scans from
// entry 0 to the first hit; it then carves the front off the hit extent, or
// grants the whole extent and moves later entries down to close the gap. A
// miss scans every entry before it reports. All of this goes through the
// single table read port, which delivers one entry per cycle to the shared
// 32-bit adder that runs the fit compare, the split compare and the offset
// add in turn. One item is in work at a time; the finished result waits in an
// output register while the next item is accepted.
// ----------------------------------------------------------------------------
module first_fit_extent_allocator
   import ffea_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_size[31:0], new_handle[47:32]
   input  logic        req_tuser,   // func
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // status[1:0], grant_handle[17:2],
                                    // grant_offset[49:18], granted_size[81:50]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam logic REG_CAPACITY = 1'b0;

   logic [DATA_W-1:0] capacity_ff;
   logic              csr_write;

   logic             tbl_wr_en;
   logic [IDX_W-1:0] tbl_wr_addr;
   entry_type        tbl_wr_data;
   logic [IDX_W-1:0] tbl_rd_addr;
   entry_type        tbl_rd_data;
   alu_op_type       alu_op;
   alu_res_type      alu_res;
   rsp_type          rsp_data;

   // capacity register
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_write && csr_paddr[2] == REG_CAPACITY) begin
         capacity_ff <= csr_pwdata;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_CAPACITY) ? capacity_ff : '0;

   ffea_ctrl #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_func       (req_tuser),
      .req_size       (req_tdata[31:0]),
      .req_new_handle (req_tdata[47:32]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_data       (rsp_data),
      .extent_capacity(capacity_ff),
      .tbl_wr_en      (tbl_wr_en),
      .tbl_wr_addr    (tbl_wr_addr),
      .tbl_wr_data    (tbl_wr_data),
      .tbl_rd_addr    (tbl_rd_addr),
      .tbl_rd_data    (tbl_rd_data),
      .alu_op         (alu_op),
      .alu_res        (alu_res)
   );

   ffea_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (tbl_wr_en),
      .wr_addr(tbl_wr_addr),
      .wr_data(tbl_wr_data),
      .rd_addr(tbl_rd_addr),
      .rd_data(tbl_rd_data)
   );

   ffea_alu u_alu (
      .op    (alu_op),
      .result(alu_res)
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {6'b0, rsp_data.granted_size, rsp_data.grant_offset,
                       rsp_data.grant_handle, rsp_data.status};

endmodule

// ----- src/ffea_table.sv -----
// ----------------------------------------------------------------------------
// ffea_table
// Extent table storage: one write port and one read port with registered
// read data. Entries hold no reset value; only written entries are used.
// ----------------------------------------------------------------------------
module ffea_table
   import ffea_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr,
   input  entry_type                      wr_data,
   input  logic [$clog2(TABLE_DEPTH)-1:0] rd_addr,
   output entry_type                      rd_data
);

   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ffea_alu.sv -----
// ----------------------------------------------------------------------------
// ffea_alu
// Shared 32-bit adder/subtractor. On subtract, carry high means a >= b.
// ----------------------------------------------------------------------------
module ffea_alu
   import ffea_pkg::*;
(
   input  alu_op_type  op,
   output alu_res_type result
);

   logic [DATA_W:0] sum;

   // a + b, or a + ~b + 1 for subtract
   assign sum = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {{DATA_W{1'b0}}, op.sub};

   assign result.res   = sum[DATA_W-1:0];
   assign result.carry = sum[DATA_W];

endmodule

// ----- src/ffea_ctrl.sv -----
// ----------------------------------------------------------------------------
// ffea_ctrl
// Sequencer of the allocator: appends extents, runs the first-fit scan
// through the table read port, carves or removes the hit entry, compacts
// the table and holds the result in an output register.
// ----------------------------------------------------------------------------
module ffea_ctrl
   import ffea_pkg::*;
#(
   parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // input channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic                           req_func,
   input  logic [DATA_W-1:0]              req_size,
   input  logic [HANDLE_W-1:0]            req_new_handle,
   // result channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output rsp_type                        rsp_data,
   // capacity register
   input  logic [DATA_W-1:0]              extent_capacity,
   // table ports
   output logic                           tbl_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0] tbl_wr_addr,
   output entry_type                      tbl_wr_data,
   output logic [$clog2(TABLE_DEPTH)-1:0] tbl_rd_addr,
   input  entry_type                      tbl_rd_data,
   // shared adder
   output alu_op_type                     alu_op,
   input  alu_res_type                    alu_res
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] ONE        = CNT_W'(1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              chk_ff, chk_in;
   logic [CNT_W-1:0]  src_ff, src_in;
   logic [IDX_W-1:0]  dst_ff, dst_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  hit_idx_ff, hit_idx_in;
   entry_type         hit_ff, hit_in;
   logic [DATA_W-1:0] diff_ff, diff_in;
   logic [DATA_W-1:0] req_ff, req_in;
   rsp_type           res_ff, res_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic accept;
   logic scan_hit;
   logic out_free;
   logic scan_more;
   logic shift_more;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign scan_more  = scan_ff < count_ff;
   assign shift_more = src_ff < count_ff;
   // size > request: no borrow and a nonzero difference
   assign scan_hit   = (state_ff == S_SCAN) && chk_ff && alu_res.carry &&
                       (alu_res.res != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_func == FUNC_ALLOC) ? S_SCAN : S_FINISH;
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               state_in = S_SPLIT_CHK;
            end else if (!scan_more && !chk_ff) begin
               state_in = S_FINISH;
            end
         end
         S_SPLIT_CHK: begin
            state_in = alu_res.carry ? S_CARVE : S_SHIFT;
         end
         S_CARVE: begin
            state_in = S_FINISH;
         end
         S_SHIFT: begin
            if (!pend_ff && !shift_more) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath, table and adder control
   always_comb begin
      count_in      = count_ff;
      scan_in       = scan_ff;
      chk_in        = 1'b0;
      src_in        = src_ff;
      dst_in        = dst_ff;
      pend_in       = 1'b0;
      hit_idx_in    = hit_idx_ff;
      hit_in        = hit_ff;
      diff_in       = diff_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      req_tready    = (state_ff == S_IDLE);
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = count_ff[IDX_W-1:0];
      tbl_wr_data   = '{handle: req_new_handle, offset: '0, size: extent_capacity};
      tbl_rd_addr   = scan_ff[IDX_W-1:0];
      alu_op        = '{a: tbl_rd_data.size, b: req_ff, sub: 1'b1};

      case (state_ff)
         S_IDLE: begin
            res_in  = '{status: ST_OK, grant_handle: '0, grant_offset: '0,
                        granted_size: '0};
            req_in  = req_size;
            scan_in = '0;
            if (accept && req_func == FUNC_ADD) begin
               // append at the end, or report a full table
               if (count_ff == FULL_COUNT) begin
                  res_in.status = ST_FULL;
               end else begin
                  tbl_wr_en = 1'b1;
                  count_in  = count_ff + ONE;
               end
            end
         end
         S_SCAN: begin
            // check the entry read last cycle, issue the next read
            if (scan_hit) begin
               hit_in     = tbl_rd_data;
               diff_in    = alu_res.res;
               hit_idx_in = IDX_W'(scan_ff - ONE);
            end else if (scan_more) begin
               chk_in  = 1'b1;
               scan_in = scan_ff + ONE;
            end else if (!chk_ff) begin
               res_in.status = ST_NOFIT;
            end
         end
         S_SPLIT_CHK: begin
            // leftover below request: grant the whole extent
            alu_op = '{a: diff_ff, b: req_ff, sub: 1'b1};
            res_in = '{status: ST_OK, grant_handle: hit_ff.handle,
                       grant_offset: hit_ff.offset,
                       granted_size: alu_res.carry ? req_ff : hit_ff.size};
            src_in = CNT_W'(hit_idx_ff) + ONE;
            dst_in = hit_idx_ff;
         end
         S_CARVE: begin
            // cut the request off the front of the hit extent
            alu_op      = '{a: hit_ff.offset, b: req_ff, sub: 1'b0};
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = hit_idx_ff;
            tbl_wr_data = '{handle: hit_ff.handle, offset: alu_res.res, size: diff_ff};
         end
         S_SHIFT: begin
            // move each later entry down by one
            tbl_rd_addr = src_ff[IDX_W-1:0];
            tbl_wr_addr = dst_ff;
            tbl_wr_data = tbl_rd_data;
            if (pend_ff) begin
               tbl_wr_en = 1'b1;
               dst_in    = dst_ff + IDX_W'(1);
            end
            if (shift_more) begin
               pend_in = 1'b1;
               src_in  = src_ff + ONE;
            end else if (!pend_ff) begin
               count_in = count_ff - ONE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         chk_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         chk_ff        <= chk_in;
         pend_ff       <= pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_ff     <= scan_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ff      <= hit_in;
      diff_ff     <= diff_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      count_ff != $past(count_ff) |->
         (count_ff == $past(count_ff) + ONE) || (count_ff == $past(count_ff) - ONE))
      else $error("entry count moved by more than one");

   a_shift_gap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) && pend_ff |-> src_ff == CNT_W'(dst_ff) + CNT_W'(2))
      else $error("compaction source and destination out of step");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |-> (state_ff == S_IDLE) || (state_ff == S_CARVE) ||
                    (state_ff == S_SHIFT))
      else $error("table write outside add, carve or compaction");

   a_result_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == S_FINISH)
      else $error("result raised outside finish");
`endif

endmodule
